### rtl/core/modular_exponentiation_core_defines.svh
// Assertion macros shared by the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

`endif

### rtl/core/mexp_pkg.sv
// Shared types and constants of the modular exponentiation core.
`timescale 1ns / 1ps
package mexp_pkg;

    // Register indexes on the configuration port (byte address 4 * index).
    localparam logic [0:0] REG_MODULUS  = 1'b0;
    localparam logic [0:0] REG_EXPONENT = 1'b1;

    // Register values after reset.
    localparam int unsigned MODULUS_RESET  = 3233;
    localparam int unsigned EXPONENT_RESET = 17;

    // Request from the sequencer to the shared modular multiplier.
    typedef struct packed {
        logic start;   // begin one modular multiply
        logic square;  // 1: base * base, 0: accumulator * base
    } t_mm_req;

endpackage

### rtl/core/mexp_modmul.sv
// Shared modular multiplier: one product, then a shift-subtract reduction.
`timescale 1ns / 1ps
module mexp_modmul import mexp_pkg::*; #(
    parameter  int DATA_WIDTH = 16,
    localparam int PROD_W     = 2 * DATA_WIDTH,
    localparam int CNT_W      = $clog2(PROD_W + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mm_req               i_req,
    input  logic [DATA_WIDTH-1:0] i_acc,
    input  logic [DATA_WIDTH-1:0] i_base,
    input  logic [DATA_WIDTH-1:0] i_modulus,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_result
);

    typedef enum logic {
        ST_IDLE,
        ST_RED
    } t_state;

    t_state                r_state;
    logic [PROD_W-1:0]     r_prod;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_mod;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_done;
    logic [DATA_WIDTH-1:0] r_result;

    logic [DATA_WIDTH-1:0] w_op_a;
    logic [DATA_WIDTH:0]   w_trial;
    logic [DATA_WIDTH:0]   w_diff;
    logic                  w_fits;
    logic [DATA_WIDTH-1:0] n_rem;

    assign w_op_a  = i_req.square ? i_base : i_acc;
    // Bring down the next product bit and subtract the modulus if it fits.
    assign w_trial = {r_rem, r_prod[PROD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_mod};
    assign w_fits  = w_trial >= {1'b0, r_mod};
    assign n_rem   = w_fits ? w_diff[DATA_WIDTH-1:0] : w_trial[DATA_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_req.start) begin
                        r_prod  <= PROD_W'(w_op_a) * PROD_W'(i_base);
                        r_rem   <= '0;
                        r_mod   <= i_modulus;
                        r_cnt   <= CNT_W'(PROD_W);
                        r_state <= ST_RED;
                    end
                end
                ST_RED: begin
                    r_rem  <= n_rem;
                    r_prod <= r_prod << 1;
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        // A zero modulus reduces everything to zero.
                        r_result <= (r_mod == '0) ? '0 : n_rem;
                        r_done   <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### rtl/core/modular_exponentiation_core.sv
// Top level of the modular exponentiation core: sequencer, registers, ports.
`timescale 1ns / 1ps
// The core raises each base word to a fixed exponent modulo a fixed modulus,
// scanning the exponent from its least significant bit (right-to-left
// square-and-multiply). Modulus and exponent live in two registers on the
// APB-style port: modulus at byte address 0, exponent at byte address 4.
// They are to be written only while the core is idle, which the user must
// ensure; the core itself does not enforce it. pready is always high. Base
// words enter on the s_axis channel, one result word leaves on the m_axis
// channel for every base word. All arithmetic runs through one shared
// modular multiplier: a single DATA_WIDTH x DATA_WIDTH product, then a
// shift-subtract reduction that takes one product bit per cycle. Each exponent
// bit costs one multiply when the bit is set, plus one squaring unless it is
// the highest set bit; a zero exponent returns 1 without any multiply. The
// core handles one word at a time: s_axis_tready is high only while it is
// idle. The result sits in an output register, so a new base word is taken
// while the previous result still waits; if the receiver stalls longer than
// one computation, the core holds its finished word until the output
// register frees up. A synchronous reset returns the registers to modulus
// 3233 and exponent 17 and drops any word in flight.
module modular_exponentiation_core import mexp_pkg::*; #(
    parameter  int DATA_WIDTH = 16,
    parameter  int EXP_WIDTH  = 16,
    localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input words.
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [DATA_WIDTH-1:0] base_value
    // Result words.
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata    // [DATA_WIDTH-1:0] power_result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_MUL,
        ST_SQR,
        ST_OUT
    } t_state;

    t_state                r_state;
    logic [DATA_WIDTH-1:0] r_modulus;
    logic [EXP_WIDTH-1:0]  r_exponent;
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_base;
    logic [EXP_WIDTH-1:0]  r_exp;
    t_mm_req               r_req;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_data;

    logic                  w_cfg_write;
    logic                  w_in_accept;
    logic                  w_out_accept;
    logic                  w_mm_done;
    logic [DATA_WIDTH-1:0] w_mm_result;

    assign pready       = 1'b1;
    assign w_cfg_write  = psel && penable && pwrite && pready;
    assign w_in_accept  = s_axis_tvalid && s_axis_tready;
    assign w_out_accept = r_out_valid && m_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= DATA_WIDTH'(MODULUS_RESET);
            r_exponent <= EXP_WIDTH'(EXPONENT_RESET);
        end else if (w_cfg_write) begin
            case (paddr[2:2])
                REG_MODULUS:  r_modulus  <= pwdata[DATA_WIDTH-1:0];
                REG_EXPONENT: r_exponent <= pwdata[EXP_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2:2])
            REG_MODULUS:  prdata = 32'(r_modulus);
            REG_EXPONENT: prdata = 32'(r_exponent);
            default:      prdata = '0;
        endcase
    end

    mexp_modmul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (r_req),
        .i_acc     (r_acc),
        .i_base    (r_base),
        .i_modulus (r_modulus),
        .o_done    (w_mm_done),
        .o_result  (w_mm_result)
    );

    // Sequencer. The accumulator starts at one and is only touched by a
    // multiply, so a zero exponent returns one unreduced. The exponent copy
    // shifts right after each squaring and the loop ends when it runs out of
    // set bits; the squaring after the highest set bit is skipped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_req       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (w_out_accept) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_accept) begin
                        r_base  <= s_axis_tdata[DATA_WIDTH-1:0];
                        r_acc   <= DATA_WIDTH'(1);
                        r_exp   <= r_exponent;
                        r_state <= ST_BIT;
                    end
                end
                ST_BIT: begin
                    if (r_exp == '0) begin
                        r_state <= ST_OUT;
                    end else if (r_exp[0]) begin
                        r_req   <= '{start: 1'b1, square: 1'b0};
                        r_state <= ST_MUL;
                    end else begin
                        r_req   <= '{start: 1'b1, square: 1'b1};
                        r_state <= ST_SQR;
                    end
                end
                ST_MUL: begin
                    if (w_mm_done) begin
                        r_acc <= w_mm_result;
                        if ((r_exp >> 1) == '0) begin
                            r_exp   <= '0;
                            r_state <= ST_OUT;
                        end else begin
                            r_req   <= '{start: 1'b1, square: 1'b1};
                            r_state <= ST_SQR;
                        end
                    end
                end
                ST_SQR: begin
                    if (w_mm_done) begin
                        r_base  <= w_mm_result;
                        r_exp   <= r_exp >> 1;
                        r_state <= ST_BIT;
                    end
                end
                ST_OUT: begin
                    // Hand the result over once the output register is free.
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_acc;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_data);

endmodule

### rtl/core/mexp_checker.sv
// Port-level assertions for the modular exponentiation core, bound to the top.
`timescale 1ns / 1ps
`include "modular_exponentiation_core_defines.svh"
module mexp_checker #(
    parameter int TDATA_W = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_tvalid,
    input logic               i_s_tready,
    input logic               i_m_tvalid,
    input logic               i_m_tready,
    input logic [TDATA_W-1:0] i_m_tdata,
    input logic               i_pready
);

    // After taking a word the core is busy computing.
    `MEXP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready)

    // No result can appear in the cycle right after a word is taken.
    `MEXP_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !$rose(i_m_tvalid))

    // A stalled result word stays valid and unchanged.
    `MEXP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata))

    // The configuration port never inserts wait states.
    `MEXP_ASSERT_NOW(a_pready_high, i_clk, i_rst_n, 1'b1, i_pready)

endmodule

bind modular_exponentiation_core mexp_checker #(
    .TDATA_W (TDATA_W)
) u_mexp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_pready   (pready)
);
